>>> hw/rtl/rmlat_pkg.sv
// ---------------------------------------------------------------------------
// rmlat_pkg
// Shared types and constants for the range-minimum lazy-add tree unit.
// ---------------------------------------------------------------------------
package rmlat_pkg;

	// Field widths fixed by the item format
	localparam int SIZE_W  = 11;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// Action codes
	typedef logic [1:0] action_t;
	localparam action_t ACT_SET   = 2'd0;
	localparam action_t ACT_ADD   = 2'd1;
	localparam action_t ACT_QUERY = 2'd2;

	// Status codes
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_BAD  = 1'b1;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		action_t                    action;
		logic [INDEX_W-1:0]         index_low;
		logic [INDEX_W-1:0]         index_high;
		logic signed [VALUE_W-1:0]  operand;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  minimum;
		logic                       status;
	} out_item_t;

	// Node store access controls
	typedef struct packed {
		logic rd;
		logic wr_min;
		logic wr_pend;
	} mem_ctl_t;

	// Tree walk sequencer states
	typedef enum logic [3:0] {
		WK_IDLE,
		WK_ENTER,
		WK_CV_RD,
		WK_CV_WR,
		WK_Q_ACC,
		WK_PD_RD,
		WK_PD_WAIT,
		WK_PD_L,
		WK_PD_R,
		WK_DESC,
		WK_RET,
		WK_PU_RL,
		WK_PU_RR,
		WK_PU_W,
		WK_DONE
	} walk_state_t;

	// Signed minimum, keeping the second operand on a tie
	function automatic logic [VALUE_W-1:0] smaller(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

endpackage

>>> hw/rtl/rmlat_store.sv
// ---------------------------------------------------------------------------
// rmlat_store
// Node store: minimum and pending-add memories, one read and one write port
// each, registered read data, with a clearing sweep after reset or on request.
// ---------------------------------------------------------------------------
module rmlat_store #(
	parameter int LEAVES = 1024,
	localparam int NW = $clog2(LEAVES) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	output logic               busy,
	input  rmlat_pkg::mem_ctl_t ctl,
	input  logic [NW-1:0]      rd_addr,
	input  logic [NW-1:0]      wr_addr,
	input  logic [31:0]        wr_min,
	input  logic [31:0]        wr_pend,
	output logic [31:0]        rd_min,
	output logic [31:0]        rd_pend
);
	import rmlat_pkg::*;

	localparam int NODES = 2 * LEAVES;

	logic [31:0]   min_mem  [NODES];
	logic [31:0]   pend_mem [NODES];
	logic          clr_q;
	logic [NW-1:0] clr_cnt_q;
	logic [31:0]   rd_min_q;
	logic [31:0]   rd_pend_q;

	// Clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == NW'(NODES - 1))
				clr_q <= 1'b0;
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (clr_q) begin
			min_mem[clr_cnt_q]  <= '0;
			pend_mem[clr_cnt_q] <= '0;
		end else begin
			if (ctl.wr_min)
				min_mem[wr_addr] <= wr_min;
			if (ctl.wr_pend)
				pend_mem[wr_addr] <= wr_pend;
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_min_q  <= min_mem[rd_addr];
			rd_pend_q <= pend_mem[rd_addr];
		end
	end

	assign busy    = clr_q;
	assign rd_min  = rd_min_q;
	assign rd_pend = rd_pend_q;

endmodule

>>> hw/rtl/rmlat_walk.sv
// ---------------------------------------------------------------------------
// rmlat_walk
// Tree walk sequencer: depth-first walk with a range stack, lazy push-down,
// pull-up of child minima and query accumulation against the node store.
// ---------------------------------------------------------------------------
module rmlat_walk #(
	parameter int LEAVES = 1024,
	localparam int IW = $clog2(LEAVES),
	localparam int NW = IW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rmlat_pkg::action_t   action,
	input  logic [IW-1:0]        first,
	input  logic [IW-1:0]        last,
	input  logic [31:0]          value,
	input  logic [IW-1:0]        root_hi,
	output logic                 busy,
	output logic                 done,
	output logic [31:0]          minimum,
	output rmlat_pkg::mem_ctl_t  ctl,
	output logic [NW-1:0]        rd_addr,
	output logic [NW-1:0]        wr_addr,
	output logic [31:0]          wr_min,
	output logic [31:0]          wr_pend,
	input  logic [31:0]          rd_min,
	input  logic [31:0]          rd_pend
);
	import rmlat_pkg::*;

	localparam int LV = IW + 1;
	localparam int DW = $clog2(LV);

	walk_state_t   state_q, state_d;
	action_t       act_q;
	logic [IW-1:0] a_q, b_q;
	logic [31:0]   v_q, p_q, lmin_q, acc_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [IW-1:0] lo_stk_q [LV];
	logic [IW-1:0] hi_stk_q [LV];

	logic [IW-1:0] cur_lo, cur_hi, cur_mid;
	logic [DW-1:0] pd;
	logic [IW-1:0] par_hi, par_mid;
	logic [NW-1:0] left_n, right_n;
	logic          leaf, covered, lleaf, rleaf, go_right;

	// Node geometry
	always_comb begin
		cur_lo   = lo_stk_q[d_q];
		cur_hi   = hi_stk_q[d_q];
		cur_mid  = cur_lo + ((cur_hi - cur_lo) >> 1);
		pd       = (d_q == '0) ? '0 : d_q - 1'b1;
		par_hi   = hi_stk_q[pd];
		par_mid  = lo_stk_q[pd] + ((hi_stk_q[pd] - lo_stk_q[pd]) >> 1);
		left_n   = {n_q[NW-2:0], 1'b0};
		right_n  = {n_q[NW-2:0], 1'b1};
		leaf     = (cur_lo == cur_hi);
		covered  = (a_q <= cur_lo) && (cur_hi <= b_q);
		lleaf    = (cur_lo == cur_mid);
		rleaf    = ((cur_hi - cur_mid) == IW'(1));
		go_right = !n_q[0] && (act_q != ACT_SET) && (b_q > par_mid);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			WK_IDLE:    if (start) state_d = WK_ENTER;
			WK_ENTER: begin
				if (act_q == ACT_SET)
					state_d = leaf ? WK_RET : WK_PD_RD;
				else
					state_d = covered ? WK_CV_RD : WK_PD_RD;
			end
			WK_CV_RD:   state_d = (act_q == ACT_ADD) ? WK_CV_WR : WK_Q_ACC;
			WK_CV_WR:   state_d = WK_RET;
			WK_Q_ACC:   state_d = WK_RET;
			WK_PD_RD:   state_d = WK_PD_WAIT;
			WK_PD_WAIT: state_d = (rd_pend == '0) ? WK_DESC : WK_PD_L;
			WK_PD_L:    state_d = WK_PD_R;
			WK_PD_R:    state_d = WK_DESC;
			WK_DESC:    state_d = WK_ENTER;
			WK_RET: begin
				if (d_q == '0)
					state_d = WK_DONE;
				else if (go_right)
					state_d = WK_ENTER;
				else if (act_q == ACT_QUERY)
					state_d = WK_RET;
				else
					state_d = WK_PU_RL;
			end
			WK_PU_RL:   state_d = WK_PU_RR;
			WK_PU_RR:   state_d = WK_PU_W;
			WK_PU_W:    state_d = WK_RET;
			WK_DONE:    state_d = WK_IDLE;
			default:    state_d = WK_IDLE;
		endcase
	end

	// Store accesses
	always_comb begin
		ctl     = '0;
		rd_addr = n_q;
		wr_addr = n_q;
		wr_min  = rd_min;
		wr_pend = rd_pend;
		case (state_q)
			WK_ENTER: begin
				if (act_q == ACT_SET && leaf) begin
					ctl.wr_min = 1'b1;
					wr_min     = v_q;
				end
			end
			WK_CV_RD, WK_PD_RD: ctl.rd = 1'b1;
			WK_CV_WR: begin
				ctl.wr_min  = 1'b1;
				ctl.wr_pend = 1'b1;
				wr_min      = rd_min + v_q;
				wr_pend     = rd_pend + (leaf ? 32'd0 : v_q);
			end
			WK_PD_WAIT: begin
				if (rd_pend != '0) begin
					ctl.wr_pend = 1'b1;
					wr_pend     = '0;
					ctl.rd      = 1'b1;
					rd_addr     = left_n;
				end
			end
			WK_PD_L: begin
				ctl.wr_min  = 1'b1;
				ctl.wr_pend = 1'b1;
				wr_addr     = left_n;
				wr_min      = rd_min + p_q;
				wr_pend     = rd_pend + (lleaf ? 32'd0 : p_q);
				ctl.rd      = 1'b1;
				rd_addr     = right_n;
			end
			WK_PD_R: begin
				ctl.wr_min  = 1'b1;
				ctl.wr_pend = 1'b1;
				wr_addr     = right_n;
				wr_min      = rd_min + p_q;
				wr_pend     = rd_pend + (rleaf ? 32'd0 : p_q);
			end
			WK_PU_RL: begin
				ctl.rd  = 1'b1;
				rd_addr = left_n;
			end
			WK_PU_RR: begin
				ctl.rd  = 1'b1;
				rd_addr = right_n;
			end
			WK_PU_W: begin
				ctl.wr_min = 1'b1;
				wr_min     = smaller(lmin_q, rd_min);
			end
			default: ;
		endcase
	end

	// Sequencer and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			d_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == WK_IDLE && start)
				d_q <= '0;
			else if (state_q == WK_DESC)
				d_q <= d_q + 1'b1;
			else if (state_q == WK_RET && d_q != '0 && !go_right)
				d_q <= pd;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			WK_IDLE: begin
				if (start) begin
					act_q       <= action;
					a_q         <= first;
					b_q         <= last;
					v_q         <= value;
					n_q         <= NW'(1);
					acc_q       <= VALUE_MAX;
					lo_stk_q[0] <= '0;
					hi_stk_q[0] <= root_hi;
				end
			end
			WK_PD_WAIT: p_q    <= rd_pend;
			WK_PU_RR:   lmin_q <= rd_min;
			WK_Q_ACC:   acc_q  <= smaller(acc_q, rd_min);
			WK_DESC: begin
				if (a_q <= cur_mid) begin
					lo_stk_q[d_q + 1'b1] <= cur_lo;
					hi_stk_q[d_q + 1'b1] <= cur_mid;
					n_q                  <= left_n;
				end else begin
					lo_stk_q[d_q + 1'b1] <= cur_mid + 1'b1;
					hi_stk_q[d_q + 1'b1] <= cur_hi;
					n_q                  <= right_n;
				end
			end
			WK_RET: begin
				if (d_q != '0) begin
					if (go_right) begin
						n_q           <= {n_q[NW-1:1], 1'b1};
						lo_stk_q[d_q] <= par_mid + 1'b1;
						hi_stk_q[d_q] <= par_hi;
					end else begin
						n_q <= {1'b0, n_q[NW-1:1]};
					end
				end
			end
			default: ;
		endcase
	end

	assign busy    = (state_q != WK_IDLE);
	assign done    = (state_q == WK_DONE);
	assign minimum = (act_q == ACT_QUERY) ? acc_q : '0;

	// Checks
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (int'(d_q) < LV))
		else $error("walk stack overrun");
	a_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_ENTER && act_q != ACT_SET) |-> !(b_q < cur_lo || a_q > cur_hi))
		else $error("walk entered a node outside the range");
	a_set_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_ENTER && act_q == ACT_SET) |-> (a_q >= cur_lo && a_q <= cur_hi))
		else $error("set walk left the entry path");
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_PD_L) |-> ($past(state_q) == WK_PD_WAIT))
		else $error("push-down write without pending read");

endmodule

>>> hw/rtl/range_min_lazy_add_tree_unit.sv
// ---------------------------------------------------------------------------
// range_min_lazy_add_tree_unit
// Segment tree over signed 32-bit entries with range minimum queries, single
// entry sets and lazy range additions, state held in two node memories.
// ---------------------------------------------------------------------------
//  channel | direction | payload     | transaction
//  cfg     | in        | cfg_data    | size_in_use write, clears the tree
//  in      | in        | in_item     | set / add / query item
//  out     | out       | out_item    | minimum and status, one per item
//
//  An item walks the tree one node at a time. A node the range only partly
//  covers has its pending add read on the way down and, when nonzero,
//  pushed to its children; on the way back a set or add pulls the child
//  minima up. A fully covered node is read, then updated or accumulated.
//  A bad item answers the next cycle. After reset and after every size
//  write a clearing pass over all 2*LEAVES node entries runs; items wait,
//  size writes are taken throughout.
//  in_ready is low while a walk is active and while a result cannot be stored.
// ---------------------------------------------------------------------------
module range_min_lazy_add_tree_unit #(
	parameter int LEAVES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rmlat_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rmlat_pkg::in_item_t               in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rmlat_pkg::out_item_t              out_item
);
	import rmlat_pkg::*;

	localparam int IW = $clog2(LEAVES);
	localparam int NW = IW + 1;
	localparam int CW = (IW + 1 > SIZE_W) ? IW + 1 : SIZE_W;

	logic [SIZE_W-1:0] size_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic [CW-1:0] sz_ext, used_sz, lo_ext, hi_ext;
	logic          bad, in_acc, cfg_acc, start;
	logic          clr_busy, walk_busy, walk_done;
	logic [31:0]   walk_min;
	mem_ctl_t      ctl;
	logic [NW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_min, wr_pend, rd_min, rd_pend;

	// Size clamp and range check
	always_comb begin
		sz_ext  = CW'(size_q);
		lo_ext  = CW'(in_item.index_low);
		hi_ext  = CW'(in_item.index_high);
		used_sz = sz_ext;
		if (sz_ext == '0)
			used_sz = CW'(1);
		else if (sz_ext > CW'(LEAVES))
			used_sz = CW'(LEAVES);
		case (in_item.action)
			ACT_SET:            bad = (lo_ext >= used_sz);
			ACT_ADD, ACT_QUERY: bad = (lo_ext > hi_ext) || (hi_ext >= used_sz);
			default:            bad = 1'b1;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_ready  = !walk_busy && !clr_busy && (!out_valid_q || out_ready);
	assign in_acc    = in_valid & in_ready;
	assign start     = in_acc & !bad;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_RESET;
		else if (cfg_acc)
			size_q <= cfg_data;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((in_acc && bad) || walk_done)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc && bad) begin
			out_item_q.minimum <= '0;
			out_item_q.status  <= ST_BAD;
		end else if (walk_done) begin
			out_item_q.minimum <= walk_min;
			out_item_q.status  <= ST_DONE;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	rmlat_walk #(.LEAVES(LEAVES)) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.action  (in_item.action),
		.first   (IW'(in_item.index_low)),
		.last    (IW'(in_item.index_high)),
		.value   (in_item.operand),
		.root_hi (IW'(used_sz - 1'b1)),
		.busy    (walk_busy),
		.done    (walk_done),
		.minimum (walk_min),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_min  (wr_min),
		.wr_pend (wr_pend),
		.rd_min  (rd_min),
		.rd_pend (rd_pend)
	);

	rmlat_store #(.LEAVES(LEAVES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_acc),
		.busy    (clr_busy),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_min  (wr_min),
		.wr_pend (wr_pend),
		.rd_min  (rd_min),
		.rd_pend (rd_pend)
	);

endmodule
